// ===== design/tlbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level branch predictor package
// Counter codes, the counter update rule and shared result types.
// ----------------------------------------------------------------------------
package tlbp_pkg;

    // Lowest branch address bit of the table select field.
    localparam int SEL_LSB = 3;

    localparam logic [31:0] MISS_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CTR_WEAK_NT   = 2'd0,
        CTR_STRONG_T  = 2'd1,
        CTR_WEAK_T    = 2'd2,
        CTR_STRONG_NT = 2'd3
    } t_ctr;

    typedef enum logic {
        RULE_JUMP_STRONG = 1'b0,
        RULE_STEP_WEAK   = 1'b1
    } t_rule;

    typedef struct packed {
        logic pred;
        logic miss;
        t_ctr next_code;
    } t_upd_result;

    // Next counter code after a resolved branch.
    function automatic t_ctr next_code(input t_rule rule, input logic taken,
                                       input t_ctr code);
        t_ctr res;
        res = code;
        unique case (code)
            CTR_WEAK_NT: begin
                if (taken) begin
                    res = (rule == RULE_JUMP_STRONG) ? CTR_STRONG_T : CTR_WEAK_T;
                end else begin
                    res = CTR_STRONG_NT;
                end
            end
            CTR_STRONG_T: begin
                res = taken ? CTR_STRONG_T : CTR_WEAK_T;
            end
            CTR_WEAK_T: begin
                if (taken) begin
                    res = CTR_STRONG_T;
                end else begin
                    res = (rule == RULE_JUMP_STRONG) ? CTR_STRONG_NT : CTR_WEAK_NT;
                end
            end
            CTR_STRONG_NT: begin
                res = taken ? CTR_WEAK_NT : CTR_STRONG_NT;
            end
            default: begin
                res = code;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== design/tlbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
module tlbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/tlbp_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counter evaluation
// Prediction, miss flag and next counter code from the current counter.
// ----------------------------------------------------------------------------
module tlbp_update (
    input  tlbp_pkg::t_ctr        i_code,
    input  logic                  i_taken,
    input  tlbp_pkg::t_rule       i_rule,
    output tlbp_pkg::t_upd_result o_result
);

    logic pred;

    always_comb begin
        pred = (i_code == tlbp_pkg::CTR_STRONG_T) || (i_code == tlbp_pkg::CTR_WEAK_T);
        o_result.pred      = pred;
        o_result.miss      = pred ^ i_taken;
        o_result.next_code = tlbp_pkg::next_code(i_rule, i_taken, i_code);
    end

endmodule

// ===== design/two_level_branch_predictor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level branch predictor
// Global history with per-address pattern tables of 2-bit counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_stall   i_branch_address, i_taken
//  result    out        o_valid / i_stall   o_predicted_taken, o_mispredicted,
//                                           o_mispredict_total
//  config    in         i_cfg_wr_en         i_cfg_wr_data (counter rule)
//
// One request per cycle while o_stall is low.
// The pattern table read is the first stage, counter update and the miss
// count the second, with a result register behind them.
// After reset a clearing pass zeroes all 2^(TABLE_SELECT_BITS +
// HISTORY_BITS) table entries (4096 by default) while o_stall is high.
// A stall on the result side holds the second stage and then the input.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_unit #(
    parameter int HISTORY_BITS      = 9,
    parameter int TABLE_SELECT_BITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_branch_address,
    input  logic        i_taken,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_predicted_taken,
    output logic        o_mispredicted,
    output logic [31:0] o_mispredict_total,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data
);

    localparam int IDX_W = TABLE_SELECT_BITS + HISTORY_BITS;
    localparam int DEPTH = 1 << IDX_W;

    logic                    r_clearing;
    logic [IDX_W-1:0]        r_clr_addr;
    tlbp_pkg::t_rule         r_rule;
    logic [HISTORY_BITS-1:0] r_hist;
    logic [HISTORY_BITS-1:0] n_hist;

    logic                    r_s1_valid;
    logic [IDX_W-1:0]        r_s1_idx;
    logic                    r_s1_taken;
    logic                    r_s1_byp;
    tlbp_pkg::t_ctr          r_s1_byp_code;

    logic [31:0]             r_miss_count;
    logic [31:0]             n_miss_count;

    logic                    r_out_valid;
    logic                    r_out_pred;
    logic                    r_out_miss;

    logic [IDX_W-1:0]        in_idx;
    logic                    in_accept;
    logic                    s1_fire;
    logic [1:0]              ram_rd;
    tlbp_pkg::t_ctr          s1_code;
    tlbp_pkg::t_upd_result   upd;
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    logic [1:0]              ram_wr_data;

    generate
        if (TABLE_SELECT_BITS == 0) begin : g_no_sel
            assign in_idx = r_hist;
        end else begin : g_sel
            assign in_idx = {i_branch_address[tlbp_pkg::SEL_LSB +: TABLE_SELECT_BITS],
                             r_hist};
        end
    endgenerate

    assign s1_fire   = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_clearing || (r_s1_valid && !s1_fire);
    assign in_accept = i_valid && !o_stall;

    // A write landing on the same edge as the read of the same entry is
    // not seen by the read-first RAM, so that value is carried along.
    assign s1_code = r_s1_byp ? r_s1_byp_code : tlbp_pkg::t_ctr'(ram_rd);

    tlbp_update u_update (
        .i_code   (s1_code),
        .i_taken  (r_s1_taken),
        .i_rule   (r_rule),
        .o_result (upd)
    );

    always_comb begin
        if (r_clearing) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = tlbp_pkg::CTR_WEAK_NT;
        end else begin
            ram_wr_en   = s1_fire;
            ram_wr_addr = r_s1_idx;
            ram_wr_data = upd.next_code;
        end
        n_hist = HISTORY_BITS'({r_hist, i_taken});
        n_miss_count = r_miss_count;
        if (upd.miss && (r_miss_count != tlbp_pkg::MISS_MAX)) begin
            n_miss_count = r_miss_count + 32'd1;
        end
    end

    tlbp_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_idx),
        .o_rd_data (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_rule       <= tlbp_pkg::RULE_JUMP_STRONG;
            r_hist       <= '0;
            r_s1_valid   <= 1'b0;
            r_miss_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
                if (r_clr_addr == {IDX_W{1'b1}}) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_wr_en) begin
                r_rule <= tlbp_pkg::t_rule'(i_cfg_wr_data);
            end
            if (in_accept) begin
                r_hist <= n_hist;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_miss_count <= n_miss_count;
                r_out_valid  <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_idx      <= in_idx;
            r_s1_taken    <= i_taken;
            r_s1_byp      <= s1_fire && (r_s1_idx == in_idx);
            r_s1_byp_code <= upd.next_code;
        end
        if (s1_fire) begin
            r_out_pred <= upd.pred;
            r_out_miss <= upd.miss;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_predicted_taken  = r_out_pred;
    assign o_mispredicted     = r_out_miss;
    assign o_mispredict_total = r_miss_count;

endmodule

// ===== tb/two_level_branch_predictor_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level branch predictor checker
// Watches the request, result and register ports of the predictor. It keeps
// its own global history, pattern counters and miss count, works out the
// expected result of every accepted request and compares each accepted result
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_unit_checker
    import tlbp_pkg::*;
#(
    parameter int HISTORY_BITS      = 9,
    parameter int TABLE_SELECT_BITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [31:0] i_branch_address,
    input  logic        i_taken,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic        i_predicted_taken,
    input  logic        i_mispredicted,
    input  logic [31:0] i_mispredict_total,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int ENTRIES = 1 << (TABLE_SELECT_BITS + HISTORY_BITS);

    typedef struct packed {
        logic        pred;
        logic        miss;
        logic [31:0] total;
    } t_branch_verdict;

    t_branch_verdict         verdict_q[$];
    t_ctr                    counters[ENTRIES];
    logic [HISTORY_BITS-1:0] history;
    logic [31:0]             miss_total;
    t_rule                   rule;

    always @(posedge i_clk) begin : watch
        t_branch_verdict exp_v;
        t_branch_verdict got_v;
        t_ctr            code;
        t_ctr            nxt;
        int unsigned     tsel;
        int unsigned     idx;

        if (!i_rst_n) begin
            foreach (counters[k]) begin
                counters[k] = CTR_WEAK_NT;
            end
            history    = '0;
            miss_total = '0;
            rule       = RULE_JUMP_STRONG;
            verdict_q.delete();
        end else begin
            // Results come out only after their request is registered, so the
            // result side is settled before this edge's request is added.
            if (i_res_valid && !i_res_stall) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected result: predicted_taken=%0b mispredicted=%0b total=%0d",
                           i_predicted_taken, i_mispredicted, i_mispredict_total);
                    o_fail_count++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    got_v = '{i_predicted_taken, i_mispredicted, i_mispredict_total};
                    if (got_v.pred !== exp_v.pred) begin
                        $error("predicted_taken: expected %0b, actual %0b",
                               exp_v.pred, got_v.pred);
                        o_fail_count++;
                    end
                    if (got_v.miss !== exp_v.miss) begin
                        $error("mispredicted: expected %0b, actual %0b",
                               exp_v.miss, got_v.miss);
                        o_fail_count++;
                    end
                    if (got_v.total !== exp_v.total) begin
                        $error("mispredict_total: expected %0d, actual %0d",
                               exp_v.total, got_v.total);
                        o_fail_count++;
                    end
                end
            end

            if (i_req_valid && !i_req_stall) begin
                tsel = (i_branch_address >> SEL_LSB) & ((1 << TABLE_SELECT_BITS) - 1);
                idx  = (tsel << HISTORY_BITS) | history;
                code = counters[idx];

                exp_v.pred = (code == CTR_STRONG_T) || (code == CTR_WEAK_T);
                exp_v.miss = exp_v.pred ^ i_taken;
                if (exp_v.miss && miss_total != MISS_MAX) begin
                    miss_total = miss_total + 1;
                end
                exp_v.total = miss_total;

                // A miss from weak not-taken or weak taken either jumps to the
                // opposite strong state or only crosses to the opposite weak one.
                if (i_taken) begin
                    case (code)
                        CTR_WEAK_NT:   nxt = (rule == RULE_STEP_WEAK) ? CTR_WEAK_T : CTR_STRONG_T;
                        CTR_STRONG_NT: nxt = CTR_WEAK_NT;
                        default:       nxt = CTR_STRONG_T;
                    endcase
                end else begin
                    case (code)
                        CTR_STRONG_T:  nxt = CTR_WEAK_T;
                        CTR_WEAK_T:    nxt = (rule == RULE_STEP_WEAK) ? CTR_WEAK_NT : CTR_STRONG_NT;
                        default:       nxt = CTR_STRONG_NT;
                    endcase
                end
                counters[idx] = nxt;
                history = (history << 1) | HISTORY_BITS'(i_taken);
                verdict_q.push_back(exp_v);
            end

            if (i_cfg_wr_en) begin
                rule = t_rule'(i_cfg_wr_data);
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ===== tb/two_level_branch_predictor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-level branch predictor testbench
// Drives resolved branches into the predictor under both counter update
// rules: a short directed run over all tables and address extremes, then
// random loop-like, biased and noisy branch streams with random idle bursts
// on both sides. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module two_level_branch_predictor_unit_tb;
    import tlbp_pkg::*;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [31:0] i_branch_address = '0;
    logic        i_taken          = 1'b0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic        o_predicted_taken;
    logic        o_mispredicted;
    logic [31:0] o_mispredict_total;
    logic        i_cfg_wr_en      = 1'b0;
    logic        i_cfg_wr_data    = 1'b0;

    int fail_count;
    int pending_branches;
    bit quiet_tail = 1'b0;

    two_level_branch_predictor_unit u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_branch_address   (i_branch_address),
        .i_taken            (i_taken),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_predicted_taken  (o_predicted_taken),
        .o_mispredicted     (o_mispredicted),
        .o_mispredict_total (o_mispredict_total),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data)
    );

    two_level_branch_predictor_unit_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_stall        (o_stall),
        .i_branch_address   (i_branch_address),
        .i_taken            (i_taken),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_predicted_taken  (o_predicted_taken),
        .i_mispredicted     (o_mispredicted),
        .i_mispredict_total (o_mispredict_total),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending_branches)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Presents one request and returns at the edge that accepts it.
    task automatic send_branch(input logic [31:0] addr, input logic tk);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_branch_address <= addr;
        i_taken          <= tk;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_branches != 0);
    endtask

    task automatic write_rule(input t_rule rule);
        i_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= rule;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly short loops with a repeating outcome pattern at one table, so
    // that history and counters settle; the rest are biased and noisy streams.
    task automatic run_branch_mix(input int count);
        int          sent;
        int          kind;
        int          len;
        int          period;
        logic [7:0]  pattern;
        logic [2:0]  tsel;
        logic        bias;
        logic [31:0] addr;
        logic        tk;
        sent = 0;
        while (sent < count) begin
            kind    = $urandom_range(0, 19);
            tsel    = 3'($urandom_range(0, 7));
            period  = $urandom_range(1, 8);
            pattern = 8'($urandom);
            bias    = 1'($urandom_range(0, 1));
            if (kind < 12) begin
                len = $urandom_range(10, 40);
            end else if (kind < 17) begin
                len = $urandom_range(1, 6);
            end else begin
                len = $urandom_range(5, 20);
            end
            for (int i = 0; i < len && sent < count; i++) begin
                addr = $urandom;
                if (kind < 12) begin
                    addr[SEL_LSB +: 3] = tsel;
                    tk = pattern[i % period];
                    if ($urandom_range(0, 15) == 0) begin
                        tk = ~tk;
                    end
                end else if (kind < 17) begin
                    tk = 1'($urandom_range(0, 1));
                end else begin
                    addr[SEL_LSB +: 3] = tsel;
                    tk = ($urandom_range(0, 7) == 0) ? ~bias : bias;
                end
                send_branch(addr, tk);
                sent++;
            end
        end
    endtask

    initial begin : stall_bursts
        int burst;
        forever begin
            @(posedge i_clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 14);
                i_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // The table is cleared after reset while the request side stalls.
        while (o_stall !== 1'b0) @(posedge i_clk);
        write_rule(RULE_JUMP_STRONG);

        // Address extremes and every table.
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'h0000_0008, 1'b1);
        send_branch(32'h0000_0010, 1'b0);
        send_branch(32'h0000_0018, 1'b1);
        send_branch(32'h0000_0020, 1'b1);
        send_branch(32'h0000_0028, 1'b0);
        send_branch(32'h0000_0030, 1'b1);
        send_branch(32'h0000_0038, 1'b1);
        // One table reached through addresses that differ only in ignored bits.
        send_branch(32'h8000_0013, 1'b1);
        send_branch(32'h7FFF_FFD4, 1'b1);
        send_branch(32'h5555_5557, 1'b0);
        send_branch(32'hAAAA_AA92, 1'b1);
        // A run of taken branches fills the history with ones and then keeps
        // hitting the same counter, walking it to strong taken.
        for (int i = 0; i < 11; i++) begin
            send_branch(32'h0000_0040 | (i & 7), 1'b1);
        end

        write_rule(RULE_STEP_WEAK);
        run_branch_mix(200);
        write_rule(RULE_JUMP_STRONG);
        run_branch_mix(200);
        write_rule(RULE_STEP_WEAK);
        run_branch_mix(100);
        quiet_tail = 1'b1;
        run_branch_mix(100);

        i_valid <= 1'b0;
        wait_drained();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("two_level_branch_predictor_unit_tb: done, clean");
        end else begin
            $display("two_level_branch_predictor_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("two_level_branch_predictor_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tlbp_pkg.sv
design/tlbp_ram.sv
design/tlbp_update.sv
design/two_level_branch_predictor_unit.sv
tb/two_level_branch_predictor_unit_checker.sv
tb/two_level_branch_predictor_unit_tb.sv
